// ----- rtl/rmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types, round tables and helper functions for the RIPEMD-160 core.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int CNT_W    = 61;   // message byte counter width
  localparam int LEN_W    = 64;   // bit length field
  localparam int ROUNDS   = 80;
  localparam int NWORDS   = 5;    // chaining / digest words

  localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_IDX = 3'(NWORDS - 1);
  localparam logic [3:0] LAST_WP  = 4'd15;
  localparam logic [3:0] LEN_LO_WP = 4'd14;
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } rmd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } rmd_out_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_in;      // store the request word
    logic wr_pad;     // store the next padding word
    logic pre;        // load working lines from chaining value
    logic rnd_en;     // run one round on both lines
    logic fin;        // fold the lines into the chaining value
    logic emit_step;  // advance the digest word pointer
    logic reinit;     // back to initial chaining value and zero count
  } rmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic wp_end;     // next write fills the block
    logic pad_final;  // next padding word is the upper length word
    logic rnd_end;    // current round is the last one
    logic idx_end;    // current digest word is the last one
  } rmd_sts_t;

  localparam logic [31:0] IV [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0 };
  localparam logic [31:0] K_L [0:4] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E };
  localparam logic [31:0] K_R [0:4] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000 };

  localparam logic [3:0] SEL_L [0:79] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13 };
  localparam logic [3:0] SEL_R [0:79] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11 };
  localparam logic [3:0] ROT_L [0:79] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6 };
  localparam logic [3:0] ROT_R [0:79] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11 };

  function automatic logic [31:0] rmd_mix(input logic [2:0] g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (g)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rmd_rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

endpackage

// ----- rtl/rmd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_datapath
// Block buffer, byte counter, padding word source, dual round lines,
// chaining value and digest word pointer.
// ----------------------------------------------------------------------------
module rmd_datapath import rmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rmd_in_t  in_data,
  input  rmd_cmd_t cmd,
  output rmd_sts_t sts,
  output rmd_out_t out_data
);

  logic [31:0]      mem [0:15];
  logic [31:0]      rd_l_r, rd_r_r;
  logic [3:0]       addr_l, addr_r;

  logic [31:0]      cv_r [0:4];
  logic [CNT_W-1:0] count_r;
  logic [3:0]       wp_r;
  logic             mark_r, len_lo_r;
  logic [6:0]       rnd_r, rnd_rd;
  logic [2:0]       idx_r;

  logic [31:0] al_r, bl_r, cl_r, dl_r, el_r;
  logic [31:0] ar_r, br_r, cr_r, dr_r, er_r;

  logic [2:0]       n_bytes;
  logic [31:0]      in_word, pad_word, wr_word;
  logic [LEN_W-1:0] bit_len;
  logic [2:0]       g_l, g_r;
  logic [31:0]      tl, tr;

  // request word: keep valid bytes, drop the marker right behind them
  always_comb begin
    n_bytes = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    for (int b = 0; b < 4; b++) begin
      if (!in_data.last || 3'(b) < n_bytes)
        in_word[8*b +: 8] = in_data.data_word[8*b +: 8];
      else if (3'(b) == n_bytes)
        in_word[8*b +: 8] = PAD_MARK;
      else
        in_word[8*b +: 8] = 8'h00;
    end
  end

  assign bit_len = {count_r, 3'b000};

  always_comb begin
    if (mark_r)
      pad_word = {24'h0, PAD_MARK};
    else if (len_lo_r)
      pad_word = bit_len[63:32];
    else if (wp_r == LEN_LO_WP)
      pad_word = bit_len[31:0];
    else
      pad_word = 32'h0;
  end

  assign wr_word = cmd.wr_in ? in_word : pad_word;

  // read one round ahead; registered read data feeds the round
  assign rnd_rd = cmd.pre ? 7'd0 : (rnd_r == LAST_RND) ? 7'd0 : rnd_r + 7'd1;
  assign addr_l = SEL_L[rnd_rd];
  assign addr_r = SEL_R[rnd_rd];

  always_ff @(posedge clk) begin
    if (cmd.wr_in || cmd.wr_pad) begin
      mem[wp_r] <= wr_word;
    end
    rd_l_r <= mem[addr_l];
    rd_r_r <= mem[addr_r];
  end

  assign g_l = rnd_r[6:4];
  assign g_r = 3'd4 - g_l;

  always_comb begin
    tl = rmd_rotl(al_r + rmd_mix(g_l, bl_r, cl_r, dl_r) + rd_l_r + K_L[g_l],
                  {1'b0, ROT_L[rnd_r]}) + el_r;
    tr = rmd_rotl(ar_r + rmd_mix(g_r, br_r, cr_r, dr_r) + rd_r_r + K_R[g_l],
                  {1'b0, ROT_R[rnd_r]}) + er_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.pre) begin
      al_r <= cv_r[0]; bl_r <= cv_r[1]; cl_r <= cv_r[2]; dl_r <= cv_r[3]; el_r <= cv_r[4];
      ar_r <= cv_r[0]; br_r <= cv_r[1]; cr_r <= cv_r[2]; dr_r <= cv_r[3]; er_r <= cv_r[4];
    end else if (cmd.rnd_en) begin
      al_r <= el_r; el_r <= dl_r; dl_r <= rmd_rotl(cl_r, 5'd10); cl_r <= bl_r; bl_r <= tl;
      ar_r <= er_r; er_r <= dr_r; dr_r <= rmd_rotl(cr_r, 5'd10); cr_r <= br_r; br_r <= tr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWORDS; i++) cv_r[i] <= IV[i];
      count_r  <= '0;
      wp_r     <= '0;
      mark_r   <= 1'b0;
      len_lo_r <= 1'b0;
      rnd_r    <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.wr_in) begin
        count_r <= count_r + CNT_W'(in_data.last ? n_bytes : 3'd4);
        wp_r    <= wp_r + 4'd1;
        mark_r  <= in_data.last && (n_bytes == 3'd4);
      end
      if (cmd.wr_pad) begin
        wp_r   <= wp_r + 4'd1;
        mark_r <= 1'b0;
        if (!mark_r && wp_r == LEN_LO_WP) len_lo_r <= 1'b1;
      end
      if (cmd.pre)    rnd_r <= '0;
      if (cmd.rnd_en) rnd_r <= rnd_r + 7'd1;
      if (cmd.fin) begin
        cv_r[0] <= cv_r[1] + cl_r + dr_r;
        cv_r[1] <= cv_r[2] + dl_r + er_r;
        cv_r[2] <= cv_r[3] + el_r + ar_r;
        cv_r[3] <= cv_r[4] + al_r + br_r;
        cv_r[4] <= cv_r[0] + bl_r + cr_r;
      end
      if (cmd.emit_step) idx_r <= (idx_r == LAST_IDX) ? 3'd0 : idx_r + 3'd1;
      if (cmd.reinit) begin
        for (int i = 0; i < NWORDS; i++) cv_r[i] <= IV[i];
        count_r  <= '0;
        wp_r     <= '0;
        mark_r   <= 1'b0;
        len_lo_r <= 1'b0;
      end
    end
  end

  assign sts.wp_end    = (wp_r == LAST_WP);
  assign sts.pad_final = !mark_r && len_lo_r;
  assign sts.rnd_end   = (rnd_r == LAST_RND);
  assign sts.idx_end   = (idx_r == LAST_IDX);

  assign out_data.digest_word = cv_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == LAST_IDX);

endmodule

// ----- rtl/rmd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_ctrl
// Sequencer: request intake, padding, compression rounds, digest output.
// ----------------------------------------------------------------------------
module rmd_ctrl import rmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rmd_sts_t sts,
  output rmd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;      // finishing a message (padding phase)
  logic       final_r, final_nxt;  // running compression is the last one

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    final_nxt = final_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_in = 1'b1;
          fin_nxt   = in_last;
          final_nxt = 1'b0;
          if (sts.wp_end)   state_nxt = S_PRE;
          else if (in_last) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.wr_pad = 1'b1;
        if (sts.wp_end) begin
          final_nxt = sts.pad_final;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        if (sts.rnd_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (final_r)    state_nxt = S_EMIT;
        else if (fin_r) state_nxt = S_PAD;
        else            state_nxt = S_IDLE;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          if (sts.idx_end) begin
            cmd.reinit = 1'b1;
            fin_nxt    = 1'b0;
            final_nxt  = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

// ----- rtl/ripemd160_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ripemd160_hash
// RIPEMD-160 digest engine: 32-bit little-endian message words in, five
// digest words out after the request marked last.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------
//  input   | in_valid/in_ready/in_data     | one message word per request
//  output  | out_valid/out_ready/out_data  | one digest word per request
//
//  The sixteenth word of a block starts a compression (operand load, 80
//  rounds with both lines stepping in parallel, chaining fold). A last
//  request adds the padding words, one or two compressions, and five
//  digest words.
//  Reset: rst_n synchronous, active low; restores the initial chaining value
//  and a zero byte count. The block buffer holds no reset.
//  Stalls: in_ready is high only while idle between words. The digest words
//  are held until taken; no new message word is taken meanwhile.
// ----------------------------------------------------------------------------
module ripemd160_hash import rmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmd_out_t out_data
);

  rmd_cmd_t cmd;   // sequencer commands
  rmd_sts_t sts;   // datapath status

  // sequencer: intake, padding, rounds, digest hand-off
  rmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // buffer, counter, round lines, chaining value
  rmd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- rtl/rmd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_checker
// Port-level checks on the digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module rmd_checker import rmd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input rmd_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input rmd_out_t out_data
);

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest word changed under stall");

  // no intake while the digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during digest output");

  // digest words run back to back up to the last one
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest burst broken");

  // last word flag matches the final index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_word == (out_data.word_index == 3'd4))
    else $error("last_word mismatch");

  // after the final word the engine accepts a new message
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_word |=> !out_valid && in_ready)
    else $error("no return to intake after digest");

endmodule

bind ripemd160_hash rmd_checker u_rmd_checker (.*);
